@@ rtl/assert_macros.svh @@
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds, consequent holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/swcv_pkg.sv @@
package swcv_pkg;

    localparam int WINDOW      = 8;
    localparam int CLASS_COUNT = 22;

    localparam int CLS_W    = 6;
    localparam int CONF_W   = 16;
    localparam int WIN_AW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W   = $clog2(WINDOW + 1);
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int SUM_W    = CONF_W + CNT_W;
    localparam int CLS_AW   = $clog2(CLASS_COUNT);
    localparam int DIV_CW   = $clog2(SUM_W);

    localparam int                ADDR_W    = 3;
    localparam logic [0:0]        REG_THR   = 1'b0;
    localparam logic [CONF_W-1:0] THR_RESET = 16'd32768;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DROP,
        S_ADD,
        S_SCAN,
        S_PREP,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic latch;
        logic drop;
        logic add;
        logic scan_init;
        logic scan_step;
        logic div_init;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic div_last;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic              voted;
        logic [CLS_W-1:0]  cls;
        logic [CONF_W-1:0] conf;
    } t_entry;

endpackage

@@ rtl/swcv_ctrl.sv @@
module swcv_ctrl import swcv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DROP;
                end
            end
            S_DROP: begin
                o_cmd.drop = 1'b1;
                n_state    = S_ADD;
            end
            S_ADD: begin
                o_cmd.add       = 1'b1;
                o_cmd.scan_init = 1'b1;
                n_state         = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // wait until the result register is free
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/swcv_dp.sv @@
module swcv_dp import swcv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [CLS_W-1:0]  i_raw_class,
    input  logic [CONF_W-1:0] i_raw_confidence,
    input  logic [CONF_W-1:0] i_threshold,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic              o_voted_valid,
    output logic [CLS_W-1:0]  o_voted_class,
    output logic [CONF_W-1:0] o_voted_confidence
);

    t_entry            r_win [WINDOW];
    t_entry            r_entry;
    logic [FILL_W-1:0] r_fill;
    logic [WIN_AW-1:0] r_oldest;
    logic [CNT_W-1:0]  r_counts [CLASS_COUNT];
    logic [SUM_W-1:0]  r_sums [CLASS_COUNT];

    logic [CLS_AW-1:0] r_idx;
    logic [CLS_AW-1:0] r_best;
    logic [CNT_W-1:0]  r_best_votes;
    logic [SUM_W-1:0]  r_best_sum;

    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [DIV_CW-1:0] r_div_cnt;

    logic              r_out_valid;
    logic              r_voted_valid;
    logic [CLS_W-1:0]  r_voted_class;
    logic [CONF_W-1:0] r_voted_conf;

    t_entry            w_old;
    logic              w_full;
    logic              w_new_voted;
    logic [FILL_W:0]   w_pos_sum;
    logic [WIN_AW-1:0] w_pos;
    logic [CLS_AW-1:0] w_old_idx;
    logic [CLS_AW-1:0] w_new_idx;
    logic [CNT_W:0]    w_rem_sh;
    logic              w_ge;

    assign w_old     = r_win[r_oldest];
    assign w_full    = (r_fill == FILL_W'(WINDOW));
    assign w_old_idx = w_old.cls[CLS_AW-1:0];
    assign w_new_idx = r_entry.cls[CLS_AW-1:0];

    assign w_new_voted = (i_raw_confidence >= i_threshold)
                      && ({1'b0, i_raw_class} < (CLS_W+1)'(CLASS_COUNT));

    // next free slot, or the oldest slot once the window is full, wrapping around the ring
    always_comb begin
        w_pos_sum = (FILL_W+1)'(r_oldest) + (FILL_W+1)'(r_fill);
        if (w_full) begin
            w_pos = r_oldest;
        end else if (w_pos_sum >= (FILL_W+1)'(WINDOW)) begin
            w_pos = WIN_AW'(w_pos_sum - (FILL_W+1)'(WINDOW));
        end else begin
            w_pos = WIN_AW'(w_pos_sum);
        end
    end

    // restoring divide, one quotient bit per cycle
    assign w_rem_sh = {r_rem, r_quo[SUM_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_best_votes});

    assign o_sts.scan_last = (r_idx == CLS_AW'(CLASS_COUNT - 1));
    assign o_sts.div_last  = (r_div_cnt == DIV_CW'(SUM_W - 1));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_oldest    <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CLASS_COUNT; c++) begin
                r_counts[c] <= '0;
                r_sums[c]   <= '0;
            end
        end else begin
            if (i_cmd.drop && w_full && w_old.voted) begin
                r_counts[w_old_idx] <= r_counts[w_old_idx] - CNT_W'(1);
                r_sums[w_old_idx]   <= r_sums[w_old_idx] - SUM_W'(w_old.conf);
            end
            if (i_cmd.add) begin
                if (r_entry.voted) begin
                    r_counts[w_new_idx] <= r_counts[w_new_idx] + CNT_W'(1);
                    r_sums[w_new_idx]   <= r_sums[w_new_idx] + SUM_W'(r_entry.conf);
                end
                if (w_full) begin
                    if (r_oldest == WIN_AW'(WINDOW - 1)) begin
                        r_oldest <= '0;
                    end else begin
                        r_oldest <= r_oldest + WIN_AW'(1);
                    end
                end else begin
                    r_fill <= r_fill + FILL_W'(1);
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_entry.voted <= w_new_voted;
            r_entry.cls   <= w_new_voted ? i_raw_class : '0;
            r_entry.conf  <= w_new_voted ? i_raw_confidence : '0;
        end
        if (i_cmd.add) begin
            r_win[w_pos] <= r_entry;
        end
        if (i_cmd.scan_init) begin
            r_idx        <= '0;
            r_best       <= '0;
            r_best_votes <= '0;
            r_best_sum   <= '0;
        end else if (i_cmd.scan_step) begin
            // strict compare keeps the lowest index on ties
            if (r_counts[r_idx] > r_best_votes) begin
                r_best       <= r_idx;
                r_best_votes <= r_counts[r_idx];
                r_best_sum   <= r_sums[r_idx];
            end
            r_idx <= r_idx + CLS_AW'(1);
        end
        if (i_cmd.div_init) begin
            r_quo     <= r_best_sum;
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem     <= w_ge ? CNT_W'(w_rem_sh - {1'b0, r_best_votes}) : CNT_W'(w_rem_sh);
            r_quo     <= {r_quo[SUM_W-2:0], w_ge};
            r_div_cnt <= r_div_cnt + DIV_CW'(1);
        end
        if (i_cmd.load_out) begin
            r_voted_valid <= (r_best_votes != '0);
            r_voted_class <= (r_best_votes != '0) ? CLS_W'(r_best) : '0;
            r_voted_conf  <= (r_best_votes != '0) ? r_quo[CONF_W-1:0] : '0;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_voted_valid      = r_voted_valid;
    assign o_voted_class      = r_voted_class;
    assign o_voted_confidence = r_voted_conf;

endmodule

@@ rtl/sliding_window_class_vote_core.sv @@
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    i_raw_class, i_raw_confidence
// out       output     o_out_valid / i_out_ready  o_voted_valid, o_voted_class,
//                                                 o_voted_confidence
// config    input      psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// a request is taken in idle and its result is loaded after these steps: drop, add,
// CLASS_COUNT scan steps, a divide setup, 16 + clog2(WINDOW+1) divide steps and the
// load; a new request is taken only once the previous result has been loaded
// a finished result sits in the output register while the next request is taken;
// the block waits in its last step only if that register is still occupied
// reset is synchronous, active low; it empties the window and clears all tallies
module sliding_window_class_vote_core import swcv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CLS_W-1:0]  i_raw_class,
    input  logic [CONF_W-1:0] i_raw_confidence,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_voted_valid,
    output logic [CLS_W-1:0]  o_voted_class,
    output logic [CONF_W-1:0] o_voted_confidence,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [CONF_W-1:0] r_threshold;
    logic              w_sel_thr;
    t_cmd              w_cmd;
    t_sts              w_sts;

    assign pready    = 1'b1;
    assign w_sel_thr = (paddr[ADDR_W-1:2] == REG_THR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THR_RESET;
        end else if (psel && penable && pwrite && w_sel_thr) begin
            r_threshold <= pwdata[CONF_W-1:0];
        end
    end

    assign prdata = w_sel_thr ? {{(32-CONF_W){1'b0}}, r_threshold} : '0;

    swcv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    swcv_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_raw_class        (i_raw_class),
        .i_raw_confidence   (i_raw_confidence),
        .i_threshold        (r_threshold),
        .i_out_ready        (i_out_ready),
        .o_out_valid        (o_out_valid),
        .o_voted_valid      (o_voted_valid),
        .o_voted_class      (o_voted_class),
        .o_voted_confidence (o_voted_confidence)
    );

endmodule

@@ rtl/swcv_checker.sv @@
`include "assert_macros.svh"

module swcv_checker import swcv_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic              o_voted_valid,
    input logic [CLS_W-1:0]  o_voted_class,
    input logic [CONF_W-1:0] o_voted_confidence,
    input logic              psel,
    input logic              pready
);

    logic w_out_stall;
    logic w_in_take;
    logic w_out_empty;
    logic w_out_vote;
    logic w_zero_payload;
    logic w_class_ok;

    assign w_out_stall    = o_out_valid && !i_out_ready;
    assign w_in_take      = i_in_valid && o_in_ready;
    assign w_out_empty    = o_out_valid && !o_voted_valid;
    assign w_out_vote     = o_out_valid && o_voted_valid;
    assign w_zero_payload = (o_voted_class == '0) && (o_voted_confidence == '0);
    assign w_class_ok     = ({1'b0, o_voted_class} < (CLS_W+1)'(CLASS_COUNT));

    // a result waits until taken
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, o_out_valid, "result dropped")

    // one request at a time: ready drops right after a request is taken
    `ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, w_in_take, !o_in_ready, "taken while busy")

    // a window with no votes reports zeros
    `ASSERT_SAME(a_empty_zero, i_clk, i_rst_n, w_out_empty, w_zero_payload, "nonzero payload")

    // a winning class is always a real class
    `ASSERT_SAME(a_class_range, i_clk, i_rst_n, w_out_vote, w_class_ok, "class out of range")

    // the config port never stalls
    `ASSERT_SAME(a_pready, i_clk, i_rst_n, psel, pready, "config port stalled")

endmodule

bind sliding_window_class_vote_core swcv_checker u_swcv_checker (.*);

@@ tb/tb_sliding_window_class_vote_core.sv @@
module tb_sliding_window_class_vote_core import swcv_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int REG_UNUSED  = 1;
    localparam int HOLD_CYCLES = 900;
    localparam int RAND_PHASES = 5;
    localparam int PHASE_ITEMS = 146;
    localparam int MAX_PRINTS  = 40;
    localparam int EXP_DEPTH   = 16;

    typedef struct packed {
        logic              valid;
        logic [CLS_W-1:0]  cls;
        logic [CONF_W-1:0] conf;
    } t_vote;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_THR,
        ROW_BAD_REG
    } t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic [CLS_W-1:0]  cls;
        logic [CONF_W-1:0] conf;
        bit                typed;
        t_vote             want;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [CLS_W-1:0]  i_raw_class;
    logic [CONF_W-1:0] i_raw_confidence;
    logic              o_out_valid;
    logic              i_out_ready;
    logic              o_voted_valid;
    logic [CLS_W-1:0]  o_voted_class;
    logic [CONF_W-1:0] o_voted_confidence;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    sliding_window_class_vote_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_raw_class        (i_raw_class),
        .i_raw_confidence   (i_raw_confidence),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_voted_valid      (o_voted_valid),
        .o_voted_class      (o_voted_class),
        .o_voted_confidence (o_voted_confidence),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // window and tally mirror
    logic [CONF_W-1:0] vote_thr = THR_RESET;
    t_entry            win_slot [WINDOW];
    int                win_fill = 0;
    int                win_head = 0;
    int                vote_cnt [CLASS_COUNT] = '{default: 0};
    int                conf_sum [CLASS_COUNT] = '{default: 0};

    // expected results in request order
    t_vote exp_fifo [EXP_DEPTH];
    int    exp_wr = 0;
    int    exp_rd = 0;
    t_vote chk_want;
    int    mismatches = 0;
    bit    hold_req = 0;
    int    hold_left = 0;
    int    burst_left = 1;

    // class out of range, low confidence, tie to lowest index, threshold edges
    t_row dir_rows [] = '{
        '{ROW_ITEM,    6'd63, 16'hFFFF, 1'b1, '{1'b0, 6'd0,  16'd0}},
        '{ROW_ITEM,    6'd0,  16'd32767, 1'b1, '{1'b0, 6'd0,  16'd0}},
        '{ROW_ITEM,    6'd21, 16'd32768, 1'b1, '{1'b1, 6'd21, 16'd32768}},
        '{ROW_ITEM,    6'd22, 16'hFFFF, 1'b1, '{1'b1, 6'd21, 16'd32768}},
        '{ROW_ITEM,    6'd21, 16'hFFFF, 1'b0, '0},
        '{ROW_ITEM,    6'd0,  16'hFFFF, 1'b0, '0},
        '{ROW_ITEM,    6'd0,  16'hFFFF, 1'b0, '0},
        '{ROW_ITEM,    6'd0,  16'd0,    1'b0, '0},
        '{ROW_ITEM,    6'd5,  16'hAAAA, 1'b0, '0},
        '{ROW_ITEM,    6'd42, 16'h5555, 1'b0, '0},
        '{ROW_THR,     6'd0,  16'd0,    1'b0, '0},
        '{ROW_ITEM,    6'd3,  16'd0,    1'b0, '0},
        '{ROW_ITEM,    6'd42, 16'd0,    1'b0, '0},
        '{ROW_BAD_REG, 6'd0,  16'hFFFF, 1'b0, '0},
        '{ROW_ITEM,    6'd7,  16'd1,    1'b0, '0},
        '{ROW_THR,     6'd0,  16'hFFFF, 1'b0, '0},
        '{ROW_ITEM,    6'd7,  16'hFFFE, 1'b0, '0},
        '{ROW_ITEM,    6'd7,  16'hFFFF, 1'b0, '0},
        '{ROW_ITEM,    6'd9,  16'hFFFF, 1'b0, '0},
        '{ROW_ITEM,    6'd9,  16'hFFFF, 1'b0, '0},
        '{ROW_ITEM,    6'd9,  16'hFFFF, 1'b0, '0},
        '{ROW_ITEM,    6'd9,  16'hFFFF, 1'b0, '0},
        '{ROW_ITEM,    6'd9,  16'hFFFF, 1'b0, '0},
        '{ROW_ITEM,    6'd9,  16'hFFFF, 1'b0, '0},
        '{ROW_ITEM,    6'd9,  16'hFFFF, 1'b0, '0},
        '{ROW_ITEM,    6'd9,  16'hFFFF, 1'b1, '{1'b1, 6'd9, 16'hFFFF}},
        '{ROW_THR,     6'd0,  16'd32768, 1'b0, '0}
    };

    initial begin
        i_clk = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < MAX_PRINTS)
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic t_vote predict_vote(input logic [CLS_W-1:0] cls,
                                           input logic [CONF_W-1:0] conf);
        t_entry ent;
        int     slot;
        int     best;
        int     best_n;
        int     c;
        t_vote  res;
        ent.voted = (conf >= vote_thr) && (cls < CLASS_COUNT);
        ent.cls   = ent.voted ? cls : '0;
        ent.conf  = ent.voted ? conf : '0;
        if (win_fill >= WINDOW) begin
            slot = win_head;
            if (win_slot[slot].voted) begin
                vote_cnt[win_slot[slot].cls] -= 1;
                conf_sum[win_slot[slot].cls] -= win_slot[slot].conf;
            end
            win_head = (slot + 1) % WINDOW;
        end else begin
            slot = (win_head + win_fill) % WINDOW;
            win_fill++;
        end
        win_slot[slot] = ent;
        if (ent.voted) begin
            vote_cnt[ent.cls] += 1;
            conf_sum[ent.cls] += ent.conf;
        end
        best   = 0;
        best_n = 0;
        for (c = 0; c < CLASS_COUNT; c++) begin
            if (vote_cnt[c] > best_n) begin
                best_n = vote_cnt[c];
                best   = c;
            end
        end
        res = '0;
        if (best_n != 0) begin
            res.valid = 1'b1;
            res.cls   = CLS_W'(best);
            res.conf  = CONF_W'(conf_sum[best] / best_n);
        end
        return res;
    endfunction

    task automatic send_decision(input logic [CLS_W-1:0] cls, input logic [CONF_W-1:0] conf,
                                 input bit typed, input t_vote typed_want);
        t_vote pred;
        i_in_valid       <= 1'b1;
        i_raw_class      <= cls;
        i_raw_confidence <= conf;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pred = predict_vote(cls, conf);
        exp_fifo[exp_wr % EXP_DEPTH] = typed ? typed_want : pred;
        exp_wr++;
    endtask

    // bursts of back-to-back requests, then a gap that may land anywhere in the pipeline
    task automatic pace_sender();
        int gap;
        int pick;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            pick = $urandom_range(0, 9);
            if (pick < 6)
                gap = $urandom_range(1, 4);
            else if (pick < 9)
                gap = $urandom_range(5, 60);
            else
                gap = $urandom_range(61, 150);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
    endtask

    task automatic cfg_write(input int idx, input logic [31:0] data);
        logic [31:0] rd;
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == int'(REG_THR))
            vote_thr = data[CONF_W-1:0];
        // read back the threshold, even after a write to an unused index
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= ADDR_W'(int'(REG_THR) * 4);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (rd !== {16'b0, vote_thr})
            report_mismatch("threshold readback", rd, vote_thr);
    endtask

    function automatic logic [CONF_W-1:0] rand_confidence();
        int pick;
        int near;
        pick = $urandom_range(0, 99);
        near = int'(vote_thr) + int'($urandom_range(0, 4)) - 2;
        if (near < 0)
            near = 0;
        if (near > 65535)
            near = 65535;
        if (pick < 50)
            return CONF_W'($urandom_range(0, 65535));
        else if (pick < 75)
            return CONF_W'(near);
        else if (pick < 87)
            return 16'hFFFF;
        else if (pick < 93)
            return 16'h0000;
        else
            return CONF_W'($urandom_range(int'(vote_thr), 65535));
    endfunction

    // receiver: ready pattern changes mode at random intervals, plus one long hold-off
    initial begin
        int mode;
        int span;
        i_out_ready <= 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 160);
            repeat (span) begin
                @(posedge i_clk);
                if (hold_req) begin
                    hold_req  = 0;
                    hold_left = HOLD_CYCLES;
                end
                if (hold_left > 0) begin
                    hold_left--;
                    i_out_ready <= 1'b0;
                end else begin
                    case (mode)
                        0: i_out_ready <= 1'b1;
                        1: i_out_ready <= $urandom_range(0, 1);
                        2: i_out_ready <= ($urandom_range(0, 7) == 0);
                        default: i_out_ready <= ($urandom_range(0, 3) != 0);
                    endcase
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (exp_wr == exp_rd) begin
                report_mismatch("result with no request pending", o_voted_class, -1);
            end else begin
                chk_want = exp_fifo[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (o_voted_valid !== chk_want.valid)
                    report_mismatch("voted_valid", o_voted_valid, chk_want.valid);
                if (o_voted_class !== chk_want.cls)
                    report_mismatch("voted_class", o_voted_class, chk_want.cls);
                if (o_voted_confidence !== chk_want.conf)
                    report_mismatch("voted_confidence", o_voted_confidence, chk_want.conf);
            end
        end
    end

    initial begin
        int ph;
        int n;
        int hot_base;
        int pick;
        logic [CLS_W-1:0] cls;
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_raw_class      <= '0;
        i_raw_confidence <= '0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_ITEM: begin
                    send_decision(dir_rows[i].cls, dir_rows[i].conf,
                                  dir_rows[i].typed, dir_rows[i].want);
                    pace_sender();
                end
                ROW_THR: cfg_write(int'(REG_THR), {16'b0, dir_rows[i].conf});
                default: cfg_write(REG_UNUSED, {16'b0, dir_rows[i].conf});
            endcase
        end

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: cfg_write(int'(REG_THR), {16'b0, THR_RESET});
                1: cfg_write(int'(REG_THR), 32'd0);
                2: cfg_write(int'(REG_THR), 32'd65535);
                default: cfg_write(int'(REG_THR), $urandom_range(0, 65535));
            endcase
            if (ph == 1)
                hold_req = 1;
            hot_base = $urandom_range(0, CLASS_COUNT - 3);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                // mostly three hot classes so tallies climb and ties show up
                if (pick < 70)
                    cls = CLS_W'(hot_base + $urandom_range(0, 2));
                else if (pick < 90)
                    cls = CLS_W'($urandom_range(0, CLASS_COUNT - 1));
                else
                    cls = CLS_W'($urandom_range(CLASS_COUNT, 63));
                send_decision(cls, rand_confidence(), 1'b0, '0);
                pace_sender();
            end
        end

        wait_idle();
        repeat (60) @(posedge i_clk);
        if (mismatches == 0 && exp_wr == exp_rd)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
